// ===== hw/rtl/oca_pkg.sv =====
`default_nettype none
package oca_pkg;

  localparam int W = 32;
  // front stage, multiplier stage, one stage per quotient bit, finish stage
  localparam int NSTG = W + 3;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_NEG = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVF     = 2'd1,
    ST_NEG_REF = 2'd2,
    ST_DIV_Z   = 2'd3
  } status_t;

  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONES = {W{1'b1}};

  typedef struct packed {
    logic [2:0]   op;
    logic         sgn;
    logic         neg;
    status_t      st;
    logic [W-1:0] res;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] dvs;
  } rec_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v, input logic sgn);
    mag = (sgn && v[W-1]) ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/overflow_checked_alu.sv =====
`default_nettype none
// checked integer alu: add, subtract, multiply, divide, negate on 32-bit operands
// input beat (in_t*): func, operand_a, operand_b; result beat (out_t*): value and
// status (ok, overflow, unsigned negate refused, divide by zero), value 0 on error.
// cfg_we with cfg_wdata sets signed_mode (1 signed, 0 unsigned); write it only
// while no beat is in flight.
// every operation runs through the same pipeline of 35 register stages: front
// decode, one multiplier stage, 32 restoring divider stages (one quotient bit
// each), and a finish stage that is the output register. throughput is one beat
// per cycle while out_tready stays high.
// each stage holds its beat while the stage after it is full and blocked, so
// empty stages keep filling while the receiver stalls; in_tready drops only
// when the whole pipeline is full. nothing is lost or repeated.
// reset empties the pipeline and sets signed mode.
module overflow_checked_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // func[2:0], operand_a[34:3], operand_b[66:35]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // result_value[31:0], status[33:32]
);
  import oca_pkg::*;

  logic              signed_mode_r;
  rec_t              rec_r   [NSTG];
  rec_t              rec_nxt [NSTG];
  logic [NSTG-1:0]   vld_r;
  logic [NSTG:0]     rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      signed_mode_r <= cfg_wdata;
    end
  end

  assign rdy[NSTG] = out_tready;

  oca_front u_front (
    .func (in_tdata[2:0]),
    .opa  (in_tdata[34:3]),
    .opb  (in_tdata[66:35]),
    .sgn  (signed_mode_r),
    .rec  (rec_nxt[0])
  );

  oca_mul u_mul (.rec_i(rec_r[0]), .rec_o(rec_nxt[1]));

  for (genvar k = 2; k < NSTG - 1; k++) begin : g_div
    oca_div_step u_step (.rec_i(rec_r[k-1]), .rec_o(rec_nxt[k]));
  end

  oca_finish u_finish (.rec_i(rec_r[NSTG-2]), .rec_o(rec_nxt[NSTG-1]));

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    assign rdy[k] = !vld_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rec_r[k] <= rec_nxt[k];
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {6'd0, rec_r[NSTG-1].st, rec_r[NSTG-1].res};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] != ST_OK |-> out_tdata[31:0] == '0)
    else $error("error beat with nonzero value");

  a_divz_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == ST_DIV_Z |-> rec_r[NSTG-1].op == FN_DIV)
    else $error("divide-by-zero status on a non-divide");

  a_negref_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == ST_NEG_REF |->
      rec_r[NSTG-1].op == FN_NEG && !rec_r[NSTG-1].sgn)
    else $error("negate refusal outside unsigned negate");

  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// ===== hw/rtl/oca_front.sv =====
`default_nettype none
module oca_front (
  input  wire logic [2:0]              func,
  input  wire logic [oca_pkg::W-1:0]   opa,
  input  wire logic [oca_pkg::W-1:0]   opb,
  input  wire logic                    sgn,
  output oca_pkg::rec_t                rec
);
  import oca_pkg::*;

  logic         na, nb;
  logic [W-1:0] sum, dif;
  logic         ucarry;

  assign na = opa[W-1];
  assign nb = opb[W-1];
  assign {ucarry, sum} = {1'b0, opa} + {1'b0, opb};
  assign dif = opa - opb;

  always_comb begin
    rec = '0;
    rec.op = func;
    rec.sgn = sgn;
    rec.st = ST_OK;
    case (func)
      FN_ADD: begin
        rec.res = sum;
        if (sgn ? (na == nb && sum[W-1] != na) : ucarry) rec.st = ST_OVF;
      end
      FN_SUB: begin
        rec.res = dif;
        if (sgn ? (na != nb && dif[W-1] != na) : (opb > opa)) rec.st = ST_OVF;
      end
      FN_MUL: begin
        rec.quo = mag(opa, sgn);
        rec.dvs = mag(opb, sgn);
        rec.neg = sgn && (na != nb) && (opa != '0) && (opb != '0);
      end
      FN_DIV: begin
        rec.quo = mag(opa, sgn);
        rec.dvs = mag(opb, sgn);
        rec.neg = sgn && (na != nb);
        if (opb == '0) rec.st = ST_DIV_Z;
        else if (sgn && opa == SMIN && opb == ONES) rec.st = ST_OVF;
      end
      FN_NEG: begin
        if (!sgn) rec.st = ST_NEG_REF;
        else if (opa == SMIN) rec.st = ST_OVF;
        else rec.res = ~opa + 1'b1;
      end
      default: rec.res = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/oca_mul.sv =====
`default_nettype none
module oca_mul (
  input  oca_pkg::rec_t rec_i,
  output oca_pkg::rec_t rec_o
);
  import oca_pkg::*;

  logic [2*W-1:0] prod;

  assign prod = rec_i.quo * rec_i.dvs;

  always_comb begin
    rec_o = rec_i;
    if (rec_i.op == FN_MUL) begin
      // full product: high half in rem, low half in quo
      rec_o.rem = prod[2*W-1:W];
      rec_o.quo = prod[W-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/oca_div_step.sv =====
`default_nettype none
module oca_div_step (
  input  oca_pkg::rec_t rec_i,
  output oca_pkg::rec_t rec_o
);
  import oca_pkg::*;

  logic [W:0] t, d;

  // restoring step: shift in next dividend bit, subtract if it fits
  assign t = {rec_i.rem, rec_i.quo[W-1]};
  assign d = t - {1'b0, rec_i.dvs};

  always_comb begin
    rec_o = rec_i;
    if (rec_i.op == FN_DIV) begin
      if (!d[W]) begin
        rec_o.rem = d[W-1:0];
        rec_o.quo = {rec_i.quo[W-2:0], 1'b1};
      end else begin
        rec_o.rem = t[W-1:0];
        rec_o.quo = {rec_i.quo[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/oca_finish.sv =====
`default_nettype none
module oca_finish (
  input  oca_pkg::rec_t rec_i,
  output oca_pkg::rec_t rec_o
);
  import oca_pkg::*;

  logic [W-1:0] lim;
  logic [W-1:0] sval;

  assign lim  = rec_i.neg ? SMIN : SMAX;
  assign sval = rec_i.neg ? (~rec_i.quo + 1'b1) : rec_i.quo;

  always_comb begin
    rec_o = rec_i;
    case (rec_i.op)
      FN_MUL: begin
        rec_o.res = sval;
        if (rec_i.rem != '0 || (rec_i.sgn && rec_i.quo > lim)) rec_o.st = ST_OVF;
      end
      FN_DIV: rec_o.res = sval;
      default: rec_o.res = rec_i.res;
    endcase
    if (rec_o.st != ST_OK) rec_o.res = '0;
  end
endmodule
`default_nettype wire
